// ===== sv/vtm_pkg.sv =====
// Shared types, codes and constants of the versioned transactional memory unit.
package vtm_pkg;

    localparam int NUM_CELLS_DEF    = 16;
    localparam int NUM_CONTEXTS_DEF = 4;
    localparam int DATA_WIDTH_DEF   = 32;

    localparam int CLOCK_W = 32;
    localparam logic [CLOCK_W-1:0] CLOCK_RESET = 32'd1;
    localparam logic [CLOCK_W-1:0] CLOCK_MAX   = 32'hFFFF_FFFF;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_ABORT = 1'b1;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_READ   = 2'd1,
        OP_WRITE  = 2'd2,
        OP_COMMIT = 2'd3
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [1:0]  ctx;
        logic [3:0]  cell_index;
        logic [31:0] wdata;
    } req_t;

    typedef struct packed {
        logic [31:0] rdata;
        logic        status;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_WBACK,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic start;
        logic buf_wr;
    } ctx_cmd_t;

endpackage

// ===== sv/vtm_cell_store.sv =====
// Cell value and version memories with one registered read port and one write port.
module vtm_cell_store #(
    parameter int NUM_CELLS  = vtm_pkg::NUM_CELLS_DEF,
    parameter int DATA_WIDTH = vtm_pkg::DATA_WIDTH_DEF,
    localparam int CellW     = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [CellW-1:0]            rd_idx,
    output logic [DATA_WIDTH-1:0]       rd_value,
    output logic [vtm_pkg::CLOCK_W-1:0] rd_version,
    input  logic                        wr,
    input  logic [CellW-1:0]            wr_idx,
    input  logic [DATA_WIDTH-1:0]       wr_value,
    input  logic [vtm_pkg::CLOCK_W-1:0] wr_version
);

    logic [DATA_WIDTH-1:0]       value_mem   [NUM_CELLS];
    logic [vtm_pkg::CLOCK_W-1:0] version_mem [NUM_CELLS];

    logic [NUM_CELLS-1:0]        written_reg;
    logic                        rd_written_reg;
    logic [DATA_WIDTH-1:0]       rd_value_reg;
    logic [vtm_pkg::CLOCK_W-1:0] rd_version_reg;

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            value_mem[wr_idx]   <= wr_value;
            version_mem[wr_idx] <= wr_version;
        end
        rd_value_reg   <= value_mem[rd_idx];
        rd_version_reg <= version_mem[rd_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (wr)
            begin
                written_reg[wr_idx] <= 1'b1;
            end
            rd_written_reg <= written_reg[rd_idx];
        end
    end

    assign rd_value   = rd_written_reg ? rd_value_reg : '0;
    assign rd_version = rd_written_reg ? rd_version_reg : '0;

endmodule

// ===== sv/vtm_ctx_table.sv =====
// Per-context start clocks, write-valid bits and the write buffer memory.
module vtm_ctx_table #(
    parameter int NUM_CELLS    = vtm_pkg::NUM_CELLS_DEF,
    parameter int NUM_CONTEXTS = vtm_pkg::NUM_CONTEXTS_DEF,
    parameter int DATA_WIDTH   = vtm_pkg::DATA_WIDTH_DEF,
    localparam int CellW       = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1,
    localparam int CtxW        = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  vtm_pkg::ctx_cmd_t           cmd,
    input  logic [CtxW-1:0]             ctx,
    input  logic [CellW-1:0]            cell_idx,
    input  logic [DATA_WIDTH-1:0]       wdata,
    input  logic [vtm_pkg::CLOCK_W-1:0] clock_now,
    output logic [vtm_pkg::CLOCK_W-1:0] start_clock,
    output logic [NUM_CELLS-1:0]        wvalid,
    input  logic [CtxW-1:0]             rd_ctx,
    input  logic [CellW-1:0]            rd_cell,
    output logic [DATA_WIDTH-1:0]       rd_data
);

    localparam int BufDepth = 1 << (CtxW + CellW);

    logic [DATA_WIDTH-1:0]       buf_mem [BufDepth];
    logic [DATA_WIDTH-1:0]       rd_data_reg;
    logic [vtm_pkg::CLOCK_W-1:0] start_clock_reg [NUM_CONTEXTS];
    logic [NUM_CELLS-1:0]        wvalid_reg      [NUM_CONTEXTS];

    always_ff @(posedge clk)
    begin
        if (cmd.buf_wr)
        begin
            buf_mem[{ctx, cell_idx}] <= wdata;
        end
        rd_data_reg <= buf_mem[{rd_ctx, rd_cell}];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_clock_reg <= '{default: '0};
            wvalid_reg      <= '{default: '0};
        end
        else if (cmd.start)
        begin
            start_clock_reg[ctx] <= clock_now;
            wvalid_reg[ctx]      <= '0;
        end
        else if (cmd.buf_wr)
        begin
            wvalid_reg[ctx][cell_idx] <= 1'b1;
        end
    end

    assign start_clock = start_clock_reg[ctx];
    assign wvalid      = wvalid_reg[ctx];
    assign rd_data     = rd_data_reg;

endmodule

// ===== sv/vtm_ctrl.sv =====
// Sequencer that executes each transaction and walks the cells with one version comparator.
module vtm_ctrl #(
    parameter int NUM_CELLS    = vtm_pkg::NUM_CELLS_DEF,
    parameter int NUM_CONTEXTS = vtm_pkg::NUM_CONTEXTS_DEF,
    parameter int DATA_WIDTH   = vtm_pkg::DATA_WIDTH_DEF,
    localparam int CellW       = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1,
    localparam int CtxW        = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  vtm_pkg::req_t               req,
    input  logic                        slot_free,
    output logic                        res_load,
    output vtm_pkg::rsp_t               res,
    output logic [CellW-1:0]            store_rd_idx,
    input  logic [DATA_WIDTH-1:0]       store_rd_value,
    input  logic [vtm_pkg::CLOCK_W-1:0] store_rd_version,
    output logic                        store_wr,
    output logic [CellW-1:0]            store_wr_idx,
    output logic [DATA_WIDTH-1:0]       store_wr_value,
    output logic [vtm_pkg::CLOCK_W-1:0] store_wr_version,
    output vtm_pkg::ctx_cmd_t           ctx_cmd,
    output logic [CtxW-1:0]             ctx_sel,
    output logic [CellW-1:0]            ctx_cell,
    output logic [DATA_WIDTH-1:0]       ctx_wdata,
    output logic [vtm_pkg::CLOCK_W-1:0] clock_now,
    input  logic [vtm_pkg::CLOCK_W-1:0] start_clock,
    input  logic [NUM_CELLS-1:0]        wvalid,
    output logic [CtxW-1:0]             buf_rd_ctx,
    output logic [CellW-1:0]            buf_rd_cell,
    input  logic [DATA_WIDTH-1:0]       buf_rd_data
);

    localparam int CntW = $clog2(NUM_CELLS + 1);
    localparam logic [CntW-1:0] CntLast = CntW'(NUM_CELLS);

    vtm_pkg::state_t             state_reg, state_next;
    vtm_pkg::req_t               txn_reg, txn_next;
    vtm_pkg::rsp_t               hold_reg, hold_next;
    logic [CntW-1:0]             cnt_reg, cnt_next;
    logic                        pend_reg, pend_next;
    logic [CellW-1:0]            prev_idx_reg, prev_idx_next;
    logic [vtm_pkg::CLOCK_W-1:0] clock_reg, clock_next;

    logic       ctx_ok;
    logic       cell_ok;
    logic       ver_ge;
    logic       scan_end;
    logic       issue;
    logic       res_done;
    logic       clock_inc;
    logic [CellW-1:0] txn_cell;

    assign txn_cell = CellW'(txn_reg.cell_index);
    assign ctx_ok   = 32'(txn_reg.ctx) < 32'(NUM_CONTEXTS);
    assign cell_ok  = 32'(txn_reg.cell_index) < 32'(NUM_CELLS);
    assign ver_ge   = store_rd_version >= start_clock;
    assign scan_end = cnt_reg == CntLast;
    assign issue    = (state_next == state_reg)
                   && (state_reg == vtm_pkg::ST_SCAN || state_reg == vtm_pkg::ST_WBACK)
                   && (cnt_reg < CntLast);

    assign store_rd_idx = (state_reg == vtm_pkg::ST_IDLE) ? CellW'(req.cell_index)
                                                          : cnt_reg[CellW-1:0];
    assign buf_rd_ctx   = (state_reg == vtm_pkg::ST_IDLE) ? CtxW'(req.ctx) : ctx_sel;
    assign buf_rd_cell  = store_rd_idx;

    assign ctx_sel          = CtxW'(txn_reg.ctx);
    assign ctx_cell         = txn_cell;
    assign ctx_wdata        = DATA_WIDTH'(txn_reg.wdata);
    assign clock_now        = clock_reg;
    assign store_wr_idx     = prev_idx_reg;
    assign store_wr_value   = buf_rd_data;
    assign store_wr_version = clock_reg;

    always_comb
    begin
        req_ready = 1'b0;
        res_done  = 1'b0;
        res       = '{rdata: '0, status: vtm_pkg::STATUS_OK};
        ctx_cmd   = '0;
        store_wr  = 1'b0;
        clock_inc = 1'b0;
        case (state_reg)
            vtm_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
            end
            vtm_pkg::ST_EXEC:
            begin
                if (!ctx_ok)
                begin
                    res_done   = 1'b1;
                    res.status = vtm_pkg::STATUS_ABORT;
                end
                else
                begin
                    case (txn_reg.op)
                        vtm_pkg::OP_START:
                        begin
                            res_done      = 1'b1;
                            ctx_cmd.start = 1'b1;
                        end
                        vtm_pkg::OP_WRITE:
                        begin
                            res_done = 1'b1;
                            if (!cell_ok)
                            begin
                                res.status = vtm_pkg::STATUS_ABORT;
                            end
                            else
                            begin
                                ctx_cmd.buf_wr = 1'b1;
                            end
                        end
                        vtm_pkg::OP_READ:
                        begin
                            res_done = 1'b1;
                            if (!cell_ok)
                            begin
                                res.status = vtm_pkg::STATUS_ABORT;
                            end
                            else if (wvalid[txn_cell])
                            begin
                                res.rdata = 32'(buf_rd_data);
                            end
                            else if (ver_ge)
                            begin
                                res.status = vtm_pkg::STATUS_ABORT;
                            end
                            else
                            begin
                                res.rdata = 32'(store_rd_value);
                            end
                        end
                        vtm_pkg::OP_COMMIT:
                        begin
                            if (clock_reg == vtm_pkg::CLOCK_MAX)
                            begin
                                res_done   = 1'b1;
                                res.status = vtm_pkg::STATUS_ABORT;
                            end
                        end
                        default:
                        begin
                            res_done   = 1'b1;
                            res.status = vtm_pkg::STATUS_ABORT;
                        end
                    endcase
                end
            end
            vtm_pkg::ST_SCAN:
            begin
                if (pend_reg && ver_ge)
                begin
                    res_done   = 1'b1;
                    res.status = vtm_pkg::STATUS_ABORT;
                end
            end
            vtm_pkg::ST_WBACK:
            begin
                store_wr = pend_reg && wvalid[prev_idx_reg];
                if (scan_end)
                begin
                    res_done  = 1'b1;
                    clock_inc = 1'b1;
                end
            end
            vtm_pkg::ST_RESP:
            begin
                res_done = 1'b1;
                res      = hold_reg;
            end
            default:
            begin
                res_done = 1'b0;
            end
        endcase
        res_load = res_done && slot_free;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vtm_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = vtm_pkg::ST_EXEC;
                end
            end
            vtm_pkg::ST_EXEC:
            begin
                if (res_done)
                begin
                    state_next = res_load ? vtm_pkg::ST_IDLE : vtm_pkg::ST_RESP;
                end
                else
                begin
                    state_next = vtm_pkg::ST_SCAN;
                end
            end
            vtm_pkg::ST_SCAN:
            begin
                if (res_done)
                begin
                    state_next = res_load ? vtm_pkg::ST_IDLE : vtm_pkg::ST_RESP;
                end
                else if (scan_end)
                begin
                    state_next = vtm_pkg::ST_WBACK;
                end
            end
            vtm_pkg::ST_WBACK:
            begin
                if (res_done)
                begin
                    state_next = res_load ? vtm_pkg::ST_IDLE : vtm_pkg::ST_RESP;
                end
            end
            vtm_pkg::ST_RESP:
            begin
                if (res_load)
                begin
                    state_next = vtm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vtm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        txn_next      = txn_reg;
        hold_next     = hold_reg;
        cnt_next      = cnt_reg;
        prev_idx_next = prev_idx_reg;
        clock_next    = clock_reg;
        pend_next     = issue;
        if (req_valid && req_ready)
        begin
            txn_next = req;
        end
        if (res_done && !slot_free)
        begin
            hold_next = res;
        end
        if (state_next != state_reg)
        begin
            cnt_next = '0;
        end
        else if (issue)
        begin
            cnt_next      = cnt_reg + CntW'(1);
            prev_idx_next = cnt_reg[CellW-1:0];
        end
        if (clock_inc)
        begin
            clock_next = clock_reg + vtm_pkg::CLOCK_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vtm_pkg::ST_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            clock_reg <= vtm_pkg::CLOCK_RESET;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            clock_reg <= clock_next;
        end
    end

    always_ff @(posedge clk)
    begin
        txn_reg      <= txn_next;
        hold_reg     <= hold_next;
        prev_idx_reg <= prev_idx_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == vtm_pkg::ST_EXEC))
        else $error("Accepted transaction did not enter execution.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (clock_reg == $past(clock_reg))
        || (clock_reg == $past(clock_reg) + vtm_pkg::CLOCK_W'(1)))
        else $error("Global clock moved by other than one.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (clock_reg != $past(clock_reg)) |-> ($past(state_reg) == vtm_pkg::ST_WBACK))
        else $error("Global clock advanced outside a commit write-back.");

    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == vtm_pkg::ST_SCAN || state_reg == vtm_pkg::ST_WBACK))
        else $error("Pending cell read outside a cell walk.");

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CntLast)
        else $error("Cell counter ran past the last cell.");

endmodule

// ===== sv/versioned_transactional_memory_unit.sv =====
// Top level of the versioned transactional memory unit with its result register.
// Each transaction names a context and an operation and returns exactly one result. Start,
// read and write occupy the unit for the accept state, in which the cell store and the
// write buffer are read, and the execute state. In a commit, one cell a cycle goes through
// the single version comparator to check for conflicts, then the cells are walked again at
// one cell a cycle and each cell the context has written is written back from its write
// buffer, both walks paced by the registered memory read ports. A conflict ends the check
// at the first conflicting cell. Results leave through an output register, so a finished
// result may wait there while the next transaction is taken.
module versioned_transactional_memory_unit #(
    parameter int NUM_CELLS    = vtm_pkg::NUM_CELLS_DEF,
    parameter int NUM_CONTEXTS = vtm_pkg::NUM_CONTEXTS_DEF,
    parameter int DATA_WIDTH   = vtm_pkg::DATA_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  vtm_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output vtm_pkg::rsp_t rsp
);

    localparam int CellW = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int CtxW  = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;

    logic                        rsp_valid_reg, rsp_valid_next;
    vtm_pkg::rsp_t               rsp_reg, rsp_next;
    logic                        slot_free;
    logic                        res_load;
    vtm_pkg::rsp_t               res;

    logic [CellW-1:0]            store_rd_idx;
    logic [DATA_WIDTH-1:0]       store_rd_value;
    logic [vtm_pkg::CLOCK_W-1:0] store_rd_version;
    logic                        store_wr;
    logic [CellW-1:0]            store_wr_idx;
    logic [DATA_WIDTH-1:0]       store_wr_value;
    logic [vtm_pkg::CLOCK_W-1:0] store_wr_version;

    vtm_pkg::ctx_cmd_t           ctx_cmd;
    logic [CtxW-1:0]             ctx_sel;
    logic [CellW-1:0]            ctx_cell;
    logic [DATA_WIDTH-1:0]       ctx_wdata;
    logic [vtm_pkg::CLOCK_W-1:0] clock_now;
    logic [vtm_pkg::CLOCK_W-1:0] start_clock;
    logic [NUM_CELLS-1:0]        wvalid;
    logic [CtxW-1:0]             buf_rd_ctx;
    logic [CellW-1:0]            buf_rd_cell;
    logic [DATA_WIDTH-1:0]       buf_rd_data;

    assign slot_free = !rsp_valid_reg || rsp_ready;

    vtm_ctrl #(
        .NUM_CELLS   (NUM_CELLS),
        .NUM_CONTEXTS(NUM_CONTEXTS),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_ready       (req_ready),
        .req             (req),
        .slot_free       (slot_free),
        .res_load        (res_load),
        .res             (res),
        .store_rd_idx    (store_rd_idx),
        .store_rd_value  (store_rd_value),
        .store_rd_version(store_rd_version),
        .store_wr        (store_wr),
        .store_wr_idx    (store_wr_idx),
        .store_wr_value  (store_wr_value),
        .store_wr_version(store_wr_version),
        .ctx_cmd         (ctx_cmd),
        .ctx_sel         (ctx_sel),
        .ctx_cell        (ctx_cell),
        .ctx_wdata       (ctx_wdata),
        .clock_now       (clock_now),
        .start_clock     (start_clock),
        .wvalid          (wvalid),
        .buf_rd_ctx      (buf_rd_ctx),
        .buf_rd_cell     (buf_rd_cell),
        .buf_rd_data     (buf_rd_data)
    );

    vtm_cell_store #(
        .NUM_CELLS (NUM_CELLS),
        .DATA_WIDTH(DATA_WIDTH)
    ) u_cell_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_idx    (store_rd_idx),
        .rd_value  (store_rd_value),
        .rd_version(store_rd_version),
        .wr        (store_wr),
        .wr_idx    (store_wr_idx),
        .wr_value  (store_wr_value),
        .wr_version(store_wr_version)
    );

    vtm_ctx_table #(
        .NUM_CELLS   (NUM_CELLS),
        .NUM_CONTEXTS(NUM_CONTEXTS),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_ctx_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (ctx_cmd),
        .ctx        (ctx_sel),
        .cell_idx   (ctx_cell),
        .wdata      (ctx_wdata),
        .clock_now  (clock_now),
        .start_clock(start_clock),
        .wvalid     (wvalid),
        .rd_ctx     (buf_rd_ctx),
        .rd_cell    (buf_rd_cell),
        .rd_data    (buf_rd_data)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (res_load)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = res;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
